// ===== hdl/vssg_pkg.sv =====
// ----------------------------------------------------------------------------
// vssg_pkg: shared types and constants of the voxel shape scan generator
// Widths, shape codes, register indexes and the structs that pass between
// the scan stepper and the membership pipeline.
// ----------------------------------------------------------------------------
package vssg_pkg;

  // Coordinate width and size width; the other data widths follow from these.
  localparam int unsigned CoordBits = 16;
  localparam int unsigned SizeBits  = 10;

  // Offsets span -2^SizeBits .. 2^SizeBits-1; bounds need one bit more.
  localparam int unsigned OfsBits = SizeBits + 1;
  localparam int unsigned BndBits = SizeBits + 2;

  // Square of an offset magnitude (up to 2^SizeBits) and a sum of three.
  localparam int unsigned SqBits  = 2 * SizeBits + 1;
  localparam int unsigned SumBits = SqBits + 2;

  // Adder width for offset plus origin before wrapping to CoordBits.
  localparam int unsigned WideBits = (CoordBits > OfsBits) ? CoordBits : OfsBits;

  // Configuration channel.
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = (CoordBits > SizeBits) ? CoordBits : SizeBits;

  localparam logic [CfgIdxBits-1:0] CFG_SHAPE_MODE = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CFG_RADIUS     = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CFG_EXTENT_X   = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CFG_EXTENT_Y   = CfgIdxBits'(3);
  localparam logic [CfgIdxBits-1:0] CFG_EXTENT_Z   = CfgIdxBits'(4);
  localparam logic [CfgIdxBits-1:0] CFG_ORIGIN_X   = CfgIdxBits'(5);
  localparam logic [CfgIdxBits-1:0] CFG_ORIGIN_Y   = CfgIdxBits'(6);
  localparam logic [CfgIdxBits-1:0] CFG_ORIGIN_Z   = CfgIdxBits'(7);

  typedef enum logic [1:0] {
    SHAPE_SPHERE   = 2'd0,
    SHAPE_CYLINDER = 2'd1,
    SHAPE_BOX      = 2'd2,
    SHAPE_CUBE     = 2'd3
  } shape_e;

  // Register file contents.
  typedef struct packed {
    shape_e                       shape_mode;
    logic [SizeBits-1:0]          radius;
    logic [SizeBits-1:0]          extent_x;
    logic [SizeBits-1:0]          extent_y;
    logic [SizeBits-1:0]          extent_z;
    logic signed [CoordBits-1:0]  origin_x;
    logic signed [CoordBits-1:0]  origin_y;
    logic signed [CoordBits-1:0]  origin_z;
  } cfg_t;

  // One examined position, as it leaves the scan stepper.
  typedef struct packed {
    logic                         idle;
    logic                         last;
    logic signed [OfsBits-1:0]    ofs_x;
    logic signed [OfsBits-1:0]    ofs_y;
    logic signed [OfsBits-1:0]    ofs_z;
    logic signed [CoordBits-1:0]  coord_x;
    logic signed [CoordBits-1:0]  coord_y;
    logic signed [CoordBits-1:0]  coord_z;
  } pos_t;

endpackage

// ===== hdl/vssg_if.sv =====
// ----------------------------------------------------------------------------
// vssg_if: channel interfaces of the voxel shape scan generator
// Input tick channel, result channel and configuration write channel, each
// a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------

// Input tick channel.
interface vssg_in_if;
  logic valid;
  logic ready;
  logic restart_scan;

  modport source (output valid, output restart_scan, input ready);
  modport sink   (input valid, input restart_scan, output ready);
endinterface

// Result channel.
interface vssg_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vssg_pkg::CoordBits-1:0]  coord_x;
  logic signed [vssg_pkg::CoordBits-1:0]  coord_y;
  logic signed [vssg_pkg::CoordBits-1:0]  coord_z;
  logic                                   inside_res;
  logic                                   last_position;
  logic                                   scan_idle;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output inside_res, output last_position, output scan_idle,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input inside_res, input last_position, input scan_idle,
                  output ready);
endinterface

// Configuration write channel.
interface vssg_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [vssg_pkg::CfgIdxBits-1:0]      index;
  logic [vssg_pkg::CfgDataBits-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/vssg_step.sv =====
// ----------------------------------------------------------------------------
// vssg_step: scan position stepper
// Holds the scan offsets and the active flag, works out the bounds of the
// current shape, reports the position of each accepted tick and steps to the
// next one. The reported position is registered for the membership stage.
// ----------------------------------------------------------------------------
module vssg_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vssg_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  input  logic                  restart_i,
  input  logic                  adv_i,
  output vssg_pkg::pos_t        pos_o,
  output logic                  pos_valid_o
);

  localparam logic signed [vssg_pkg::BndBits-1:0] BndOne = vssg_pkg::BndBits'(1);

  // Offset plus origin, wrapped to the coordinate width.
  function automatic logic signed [vssg_pkg::CoordBits-1:0] world(
    input logic signed [vssg_pkg::OfsBits-1:0]   ofs,
    input logic signed [vssg_pkg::CoordBits-1:0] org
  );
    logic signed [vssg_pkg::WideBits-1:0] sum;
    sum = vssg_pkg::WideBits'(ofs) + vssg_pkg::WideBits'(org);
    return sum[vssg_pkg::CoordBits-1:0];
  endfunction

  logic                                 take;
  logic                                 act_q, act_d;
  logic signed [vssg_pkg::OfsBits-1:0]  ofs_x_q, ofs_y_q, ofs_z_q;
  logic signed [vssg_pkg::OfsBits-1:0]  ofs_x_d, ofs_y_d, ofs_z_d;
  logic signed [vssg_pkg::OfsBits-1:0]  cur_x, cur_y, cur_z;
  logic signed [vssg_pkg::BndBits-1:0]  r_ext, ex_ext, ey_ext, ez_ext;
  logic signed [vssg_pkg::BndBits-1:0]  st_x, st_y, st_z, en_x, en_y, en_z;
  logic signed [vssg_pkg::BndBits-1:0]  inc_x, inc_y, inc_z;
  logic                                 active, empty, live, last;
  vssg_pkg::pos_t                       pos_d, pos_q;
  logic                                 v1_q;

  assign take = in_valid_i & adv_i;

  // Bounds of the scan volume for the current shape, per axis.
  always_comb begin
    r_ext  = $signed({2'b00, cfg_i.radius});
    ex_ext = $signed({2'b00, cfg_i.extent_x});
    ey_ext = $signed({2'b00, cfg_i.extent_y});
    ez_ext = $signed({2'b00, cfg_i.extent_z});
    case (cfg_i.shape_mode)
      vssg_pkg::SHAPE_SPHERE: begin
        st_x = -r_ext; en_x = r_ext + BndOne;
        st_z = -r_ext; en_z = r_ext + BndOne;
        st_y = -r_ext; en_y = r_ext + BndOne;
      end
      vssg_pkg::SHAPE_CYLINDER: begin
        st_x = -r_ext; en_x = r_ext + BndOne;
        st_z = -r_ext; en_z = r_ext + BndOne;
        st_y = '0;     en_y = ey_ext;
      end
      vssg_pkg::SHAPE_BOX: begin
        st_x = '0; en_x = ex_ext;
        st_z = '0; en_z = ez_ext;
        st_y = '0; en_y = ey_ext;
      end
      default: begin
        st_x = '0; en_x = ex_ext;
        st_z = '0; en_z = ex_ext;
        st_y = '0; en_y = ex_ext;
      end
    endcase
  end

  // Current position, scan liveness and the step to the next position.
  always_comb begin
    active = restart_i | act_q;
    cur_x  = restart_i ? st_x[vssg_pkg::OfsBits-1:0] : ofs_x_q;
    cur_y  = restart_i ? st_y[vssg_pkg::OfsBits-1:0] : ofs_y_q;
    cur_z  = restart_i ? st_z[vssg_pkg::OfsBits-1:0] : ofs_z_q;
    empty  = (st_x >= en_x) || (st_y >= en_y) || (st_z >= en_z);
    live   = active & ~empty;

    inc_x = $signed({cur_x[vssg_pkg::OfsBits-1], cur_x}) + BndOne;
    inc_y = $signed({cur_y[vssg_pkg::OfsBits-1], cur_y}) + BndOne;
    inc_z = $signed({cur_z[vssg_pkg::OfsBits-1], cur_z}) + BndOne;

    ofs_x_d = cur_x;
    ofs_y_d = cur_y;
    ofs_z_d = cur_z;
    last    = 1'b0;
    if (live) begin
      if (inc_y < en_y) begin
        ofs_y_d = inc_y[vssg_pkg::OfsBits-1:0];
      end else begin
        ofs_y_d = st_y[vssg_pkg::OfsBits-1:0];
        if (inc_z < en_z) begin
          ofs_z_d = inc_z[vssg_pkg::OfsBits-1:0];
        end else begin
          ofs_z_d = st_z[vssg_pkg::OfsBits-1:0];
          if (inc_x < en_x) begin
            ofs_x_d = inc_x[vssg_pkg::OfsBits-1:0];
          end else begin
            ofs_x_d = st_x[vssg_pkg::OfsBits-1:0];
            last    = 1'b1;
          end
        end
      end
    end
    act_d = live & ~last;

    pos_d.idle    = ~live;
    pos_d.last    = last;
    pos_d.ofs_x   = cur_x;
    pos_d.ofs_y   = cur_y;
    pos_d.ofs_z   = cur_z;
    pos_d.coord_x = live ? world(cur_x, cfg_i.origin_x) : '0;
    pos_d.coord_y = live ? world(cur_y, cfg_i.origin_y) : '0;
    pos_d.coord_z = live ? world(cur_z, cfg_i.origin_z) : '0;
  end

  // Scan state, updated on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      ofs_x_q <= '0;
      ofs_y_q <= '0;
      ofs_z_q <= '0;
    end else if (take) begin
      act_q   <= act_d;
      ofs_x_q <= ofs_x_d;
      ofs_y_q <= ofs_y_d;
      ofs_z_q <= ofs_z_d;
    end
  end

  // Position register feeding the membership pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o       = pos_q;
  assign pos_valid_o = v1_q;

endmodule

// ===== hdl/vssg_member.sv =====
// ----------------------------------------------------------------------------
// vssg_member: shape membership pipeline and result register
// Squares the offsets of a reported position in one stage, then adds and
// compares them against the squared radius into the result register. Also
// produces the advance enable that stalls the whole pipeline.
// ----------------------------------------------------------------------------
module vssg_member (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vssg_pkg::shape_e              shape_mode_i,
  input  logic [vssg_pkg::SizeBits-1:0] radius_i,
  input  vssg_pkg::pos_t                pos_i,
  input  logic                          pos_valid_i,
  output logic                          adv_o,
  vssg_out_if.source                    res_o
);

  logic [vssg_pkg::OfsBits-1:0]   abs_x, abs_y, abs_z;
  logic [vssg_pkg::SqBits-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [2*vssg_pkg::SizeBits-1:0] r_sq_q;
  vssg_pkg::pos_t                 pos2_q;
  logic                           v2_q, v3_q;
  logic [vssg_pkg::SumBits-1:0]   sum_xz, sum_xyz;
  logic                           in_shape;

  logic signed [vssg_pkg::CoordBits-1:0] coord_x_q, coord_y_q, coord_z_q;
  logic                                  inside_q, last_q, idle_q;

  // The whole pipeline moves when the result register is free or taken.
  assign adv_o = ~v3_q | res_o.ready;

  // Offset magnitudes; the most negative offset maps to 2^SizeBits.
  always_comb begin
    abs_x = pos_i.ofs_x[vssg_pkg::OfsBits-1] ? (~pos_i.ofs_x + 1'b1) : pos_i.ofs_x;
    abs_y = pos_i.ofs_y[vssg_pkg::OfsBits-1] ? (~pos_i.ofs_y + 1'b1) : pos_i.ofs_y;
    abs_z = pos_i.ofs_z[vssg_pkg::OfsBits-1] ? (~pos_i.ofs_z + 1'b1) : pos_i.ofs_z;
  end

  // Square stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_o) begin
      v2_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && pos_valid_i) begin
      pos2_q <= pos_i;
      sq_x_q <= vssg_pkg::SqBits'(abs_x) * vssg_pkg::SqBits'(abs_x);
      sq_y_q <= vssg_pkg::SqBits'(abs_y) * vssg_pkg::SqBits'(abs_y);
      sq_z_q <= vssg_pkg::SqBits'(abs_z) * vssg_pkg::SqBits'(abs_z);
      r_sq_q <= radius_i * radius_i;
    end
  end

  // Distance compare for the configured shape.
  always_comb begin
    sum_xz  = vssg_pkg::SumBits'(sq_x_q) + vssg_pkg::SumBits'(sq_z_q);
    sum_xyz = sum_xz + vssg_pkg::SumBits'(sq_y_q);
    case (shape_mode_i)
      vssg_pkg::SHAPE_SPHERE:   in_shape = (sum_xyz <= vssg_pkg::SumBits'(r_sq_q));
      vssg_pkg::SHAPE_CYLINDER: in_shape = (sum_xz <= vssg_pkg::SumBits'(r_sq_q));
      default:                  in_shape = 1'b1;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_o) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && v2_q) begin
      coord_x_q <= pos2_q.coord_x;
      coord_y_q <= pos2_q.coord_y;
      coord_z_q <= pos2_q.coord_z;
      inside_q  <= in_shape & ~pos2_q.idle;
      last_q    <= pos2_q.last;
      idle_q    <= pos2_q.idle;
    end
  end

  assign res_o.valid         = v3_q;
  assign res_o.coord_x       = coord_x_q;
  assign res_o.coord_y       = coord_y_q;
  assign res_o.coord_z       = coord_z_q;
  assign res_o.inside_res    = inside_q;
  assign res_o.last_position = last_q;
  assign res_o.scan_idle     = idle_q;

endmodule

// ===== hdl/voxel_shape_scan_generator_top.sv =====
// ----------------------------------------------------------------------------
// voxel_shape_scan_generator_top: voxel shape scan generator
// Every input beat yields exactly one result beat. A beat with restart_scan
// set starts a scan of the bounding volume of the configured sphere,
// cylinder, box or cube (x outermost, then z, then y) and reports its first
// position; later beats report the following positions, with inside_res
// set where the position belongs to the shape and last_position on the
// final one. Beats with no scan running report scan_idle. The block takes
// one beat per cycle unless the output stalls; each beat passes through the
// position stepper register, the squaring multipliers and the distance
// compare into the result register. The whole pipeline stalls while a
// result waits on the output. Configuration writes are always taken and
// must only be issued while no beat is in flight.
// ----------------------------------------------------------------------------
module voxel_shape_scan_generator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  vssg_in_if.sink      item_i,
  vssg_out_if.source   result_o,
  vssg_cfg_if.sink     cfg_i
);

  vssg_pkg::cfg_t  cfg_q;
  vssg_pkg::pos_t  pos;
  logic            pos_valid;
  logic            adv;

  // Register file; writes are taken in every cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vssg_pkg::CFG_SHAPE_MODE:
          cfg_q.shape_mode <= vssg_pkg::shape_e'(cfg_i.data[1:0]);
        vssg_pkg::CFG_RADIUS:
          cfg_q.radius <= cfg_i.data[vssg_pkg::SizeBits-1:0];
        vssg_pkg::CFG_EXTENT_X:
          cfg_q.extent_x <= cfg_i.data[vssg_pkg::SizeBits-1:0];
        vssg_pkg::CFG_EXTENT_Y:
          cfg_q.extent_y <= cfg_i.data[vssg_pkg::SizeBits-1:0];
        vssg_pkg::CFG_EXTENT_Z:
          cfg_q.extent_z <= cfg_i.data[vssg_pkg::SizeBits-1:0];
        vssg_pkg::CFG_ORIGIN_X:
          cfg_q.origin_x <= cfg_i.data[vssg_pkg::CoordBits-1:0];
        vssg_pkg::CFG_ORIGIN_Y:
          cfg_q.origin_y <= cfg_i.data[vssg_pkg::CoordBits-1:0];
        vssg_pkg::CFG_ORIGIN_Z:
          cfg_q.origin_z <= cfg_i.data[vssg_pkg::CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // Input beats are taken whenever the pipeline advances.
  assign item_i.ready = adv;

  vssg_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (item_i.valid),
    .restart_i   (item_i.restart_scan),
    .adv_i       (adv),
    .pos_o       (pos),
    .pos_valid_o (pos_valid)
  );

  vssg_member u_member (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shape_mode_i (cfg_q.shape_mode),
    .radius_i     (cfg_q.radius),
    .pos_i        (pos),
    .pos_valid_i  (pos_valid),
    .adv_o        (adv),
    .res_o        (result_o)
  );

endmodule

// ===== hdl/vssg_checker.sv =====
// ----------------------------------------------------------------------------
// vssg_checker: port-level checks of the voxel shape scan generator
// Watches the result and configuration channels of the top level and is
// attached to it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module vssg_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [vssg_pkg::CoordBits-1:0] coord_x_i,
  input  logic signed [vssg_pkg::CoordBits-1:0] coord_y_i,
  input  logic signed [vssg_pkg::CoordBits-1:0] coord_z_i,
  input  logic                                  inside_res_i,
  input  logic                                  last_position_i,
  input  logic                                  scan_idle_i,
  input  logic                                  cfg_ready_i
);

  // A stalled result beat stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(coord_x_i) && $stable(coord_y_i) &&
      $stable(coord_z_i) && $stable(inside_res_i) && $stable(last_position_i) &&
      $stable(scan_idle_i))
    else $error("result payload changed while stalled");

  // An idle beat carries no position, membership or end-of-scan flag.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scan_idle_i |-> coord_x_i == '0 && coord_y_i == '0 &&
      coord_z_i == '0 && !inside_res_i && !last_position_i)
    else $error("idle result beat carries nonzero fields");

  // The register file never backpressures its write channel.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind voxel_shape_scan_generator_top vssg_checker u_vssg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .coord_x_i       (result_o.coord_x),
  .coord_y_i       (result_o.coord_y),
  .coord_z_i       (result_o.coord_z),
  .inside_res_i    (result_o.inside_res),
  .last_position_i (result_o.last_position),
  .scan_idle_i     (result_o.scan_idle),
  .cfg_ready_i     (cfg_i.ready)
);
